[hdl/wpp_pkg.sv]
// Shared types and constants for the windowed top-3 peak picker.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package wpp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LAT_BITS    = 16;
    localparam int TOTAL_BITS  = 16;
    localparam int TOP_COUNT   = 3;
    localparam int RANK_BITS   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int KEEP_BITS   = $clog2(TOP_COUNT + 1);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [LAT_BITS-1:0] WINDOW_START_RST = LAT_BITS'(312);
    localparam logic [LAT_BITS-1:0] WINDOW_END_RST   = LAT_BITS'(512);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_START = 1'b0,
        REG_WINDOW_END   = 1'b1
    } wpp_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [LAT_BITS-1:0]           latency;
        logic                          end_of_record;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] peak_amplitude;
        logic [LAT_BITS-1:0]           peak_latency;
        logic [RANK_BITS-1:0]          rank;
        logic                          found;
        logic                          last;
        logic [TOTAL_BITS-1:0]         total_reported;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] amp;
        logic [LAT_BITS-1:0]           lat;
    } peak_t;

    typedef peak_t [TOP_COUNT-1:0] peak_arr_t;

    // candidate peak closed by the current sample
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] amp;
        logic [LAT_BITS-1:0]           lat;
    } peak_offer_t;

    // ranked list, entry 0 largest, count entries valid
    typedef struct packed {
        peak_arr_t             entry;
        logic [KEEP_BITS-1:0]  count;
    } peak_list_t;

endpackage

`default_nettype wire

[hdl/wpp_run_tracker.sv]
// Run tracker: follows runs of equal samples and flags a closed local maximum.
// Depends on wpp_pkg.
`default_nettype none

module wpp_run_tracker
    import wpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    output peak_offer_t offer
);

    logic                          open_reg, open_next;
    logic                          rose_reg, rose_next;
    logic signed [SAMPLE_BITS-1:0] run_value_reg, run_value_next;
    logic [LAT_BITS-1:0]           run_latency_reg, run_latency_next;
    logic                          differs;

    always_comb
    begin
        differs = (item.sample != run_value_reg);

        // run closes lower than it is, after rising into it
        offer.valid = open_reg && differs && rose_reg && (item.sample < run_value_reg);
        offer.amp   = run_value_reg;
        offer.lat   = run_latency_reg;

        open_next        = open_reg;
        rose_next        = rose_reg;
        run_value_next   = run_value_reg;
        run_latency_next = run_latency_reg;

        if (!open_reg)
        begin
            open_next        = 1'b1;
            rose_next        = 1'b0;
            run_value_next   = item.sample;
            run_latency_next = item.latency;
        end
        else if (differs)
        begin
            rose_next        = (item.sample > run_value_reg);
            run_value_next   = item.sample;
            run_latency_next = item.latency;
        end

        // record end: start over on the next sample
        if (item.end_of_record)
        begin
            open_next = 1'b0;
            rose_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rose_reg <= 1'b0;
        end
        else if (step)
        begin
            open_reg <= open_next;
            rose_reg <= rose_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            run_value_reg   <= run_value_next;
            run_latency_reg <= run_latency_next;
        end
    end

endmodule

`default_nettype wire

[hdl/wpp_top_list.sv]
// Ranked list of the largest in-window peaks, parallel compare and insert.
// Depends on wpp_pkg.
`default_nettype none

module wpp_top_list
    import wpp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                flush,
    input  logic [LAT_BITS-1:0] window_start,
    input  logic [LAT_BITS-1:0] window_end,
    input  peak_offer_t         offer,
    output peak_list_t          list_next
);

    peak_arr_t            entry_reg;
    logic [KEEP_BITS-1:0] count_reg;
    logic [TOP_COUNT-1:0] ge;
    logic [TOP_COUNT:0]   above;
    peak_arr_t            shifted;
    peak_t                cand;
    logic                 in_window;
    logic                 insert;

    always_comb
    begin
        cand.amp  = offer.amp;
        cand.lat  = offer.lat;
        in_window = (offer.lat >= window_start) && (offer.lat <= window_end);

        // ge[i]: kept entry i stays ahead of the candidate (ties favor the earlier peak)
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            ge[i] = (KEEP_BITS'(i) < count_reg) && !(offer.amp > entry_reg[i].amp);
        end
        above = {ge, 1'b1};

        shifted[0] = cand;
        for (int j = 1; j < TOP_COUNT; j++)
        begin
            shifted[j] = entry_reg[j-1];
        end

        insert = offer.valid && in_window && !ge[TOP_COUNT-1];

        list_next.entry = entry_reg;
        list_next.count = count_reg;
        if (insert)
        begin
            for (int j = 0; j < TOP_COUNT; j++)
            begin
                if (!ge[j])
                begin
                    list_next.entry[j] = above[j] ? cand : shifted[j];
                end
            end
            if (count_reg < KEEP_BITS'(TOP_COUNT))
            begin
                list_next.count = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= flush ? '0 : list_next.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            entry_reg <= list_next.entry;
        end
    end

endmodule

`default_nettype wire

[hdl/wpp_result_drain.sv]
// Result serializer: emits a captured ranked list one transaction per cycle while result_stall is low,
// or a single not-found item for an empty list. Keeps the saturating total of reported peaks. Depends on wpp_pkg.
`default_nettype none

module wpp_result_drain
    import wpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  peak_list_t list,
    input  logic       result_stall,
    output logic       result_valid,
    output out_item_t  result_item,
    output logic       free
);

    logic                  valid_reg, valid_next;
    out_item_t             out_reg, out_next;
    peak_arr_t             rest_reg, rest_next;
    logic [KEEP_BITS-1:0]  left_reg, left_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next, total_inc;
    logic                  pop;

    always_comb
    begin
        pop       = valid_reg && !result_stall;
        free      = !valid_reg || (pop && out_reg.last);
        total_inc = (total_reg == '1) ? total_reg : total_reg + 1'b1;

        valid_next = valid_reg;
        out_next   = out_reg;
        rest_next  = rest_reg;
        left_next  = left_reg;
        total_next = total_reg;

        if (load)
        begin
            valid_next = 1'b1;
            if (list.count == '0)
            begin
                out_next                = '0;
                out_next.last           = 1'b1;
                out_next.total_reported = total_reg;
                left_next               = '0;
            end
            else
            begin
                out_next.peak_amplitude = list.entry[0].amp;
                out_next.peak_latency   = list.entry[0].lat;
                out_next.rank           = '0;
                out_next.found          = 1'b1;
                out_next.last           = (list.count == KEEP_BITS'(1));
                out_next.total_reported = total_inc;
                total_next              = total_inc;
                rest_next               = peak_arr_t'(list.entry >> $bits(peak_t));
                left_next               = list.count - 1'b1;
            end
        end
        else if (pop)
        begin
            if (left_reg != '0)
            begin
                out_next.peak_amplitude = rest_reg[0].amp;
                out_next.peak_latency   = rest_reg[0].lat;
                out_next.rank           = RANK_BITS'(out_reg.rank + 1'b1);
                out_next.last           = (left_reg == KEEP_BITS'(1));
                out_next.total_reported = total_inc;
                total_next              = total_inc;
                rest_next               = peak_arr_t'(rest_reg >> $bits(peak_t));
                left_next               = left_reg - 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        rest_reg <= rest_next;
    end

    assign result_valid = valid_reg;
    assign result_item  = out_reg;

endmodule

`default_nettype wire

[hdl/windowed_top3_peak_picker.sv]
// A record end waits in the input register until the previous record's last result is taken; its
// results then come from the output register. Throughput: one sample per cycle unless a record end
// is held; a record end emits up to 3 results, one per cycle while result_stall is low, set by the
// single output register. Asynchronous active-low reset clears record state, the reported total and
// sets the window to its default limits.
// Depends on wpp_pkg, wpp_run_tracker, wpp_top_list, wpp_result_drain.
`default_nettype none

module windowed_top3_peak_picker
    import wpp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  in_item_t                 sample_item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output out_item_t                result_item,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                in_valid_reg;
    in_item_t            in_reg;
    logic                advance;
    logic                accept;
    logic                drain_free;
    logic [LAT_BITS-1:0] window_start_reg;
    logic [LAT_BITS-1:0] window_end_reg;
    peak_offer_t         offer;
    peak_list_t          list_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= WINDOW_START_RST;
            window_end_reg   <= WINDOW_END_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wpp_reg_e'(cfg_index))
                REG_WINDOW_START: window_start_reg <= cfg_data[LAT_BITS-1:0];
                REG_WINDOW_END:   window_end_reg   <= cfg_data[LAT_BITS-1:0];
            endcase
        end
    end

    // input register; only a record end has to wait for the output side
    assign advance      = in_valid_reg && (!in_reg.end_of_record || drain_free);
    assign sample_stall = in_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= sample_item;
        end
    end

    wpp_run_tracker u_run (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .offer (offer)
    );

    wpp_top_list u_list (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .flush        (in_reg.end_of_record),
        .window_start (window_start_reg),
        .window_end   (window_end_reg),
        .offer        (offer),
        .list_next    (list_next)
    );

    wpp_result_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && in_reg.end_of_record),
        .list         (list_next),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item),
        .free         (drain_free)
    );

`ifndef SYNTHESIS
    // input side only waits on a pending record end
    a_stall_only_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (in_valid_reg && in_reg.end_of_record))
        else $error("input stalled without a pending record end");

    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_item.found) |-> result_item.last)
        else $error("not-found result is not the last of its record");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_item.found) |->
            (result_item.peak_amplitude == '0 && result_item.peak_latency == '0
             && result_item.rank == '0))
        else $error("not-found result carries peak data");

    a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result_item.last) |=>
            (result_valid && result_item.found
             && result_item.rank == RANK_BITS'($past(result_item.rank) + 1'b1)))
        else $error("rank does not advance within a record");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for windowed_top3_peak_picker: a queue-fed driver, a monitor
// that predicts the top-3 windowed peaks of each record and compares every result.
// Depends on wpp_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_top
    import wpp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        in_item_t item;
        logic     drain_first;  // hold this sample until no report is owed
    } queued_sample_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    in_item_t                 sample_item  = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    out_item_t                result_item;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

    queued_sample_t sample_backlog[$];
    out_item_t      peak_reports_q[$];
    int             reports_owed   = 0;
    int             send_idle_pct  = 0;
    int             stall_pct      = 0;
    int             error_count    = 0;
    int             quiet_cycles   = 0;

    // predictor state
    logic [LAT_BITS-1:0]           win_lo         = WINDOW_START_RST;
    logic [LAT_BITS-1:0]           win_hi         = WINDOW_END_RST;
    logic                          run_open       = 1'b0;
    logic                          run_climbed    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] run_level      = '0;
    logic [LAT_BITS-1:0]           run_lat        = '0;
    logic signed [SAMPLE_BITS-1:0] top_amp [TOP_COUNT];
    logic [LAT_BITS-1:0]           top_lat [TOP_COUNT];
    int                            kept           = 0;
    logic [TOTAL_BITS-1:0]         reported_total = '0;

    windowed_top3_peak_picker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // insert a windowed peak into the ranked list; an equal later peak stays below
    function automatic void rank_peak(logic signed [SAMPLE_BITS-1:0] amp,
                                      logic [LAT_BITS-1:0] lat);
        int slot;
        int j;
        if (lat < win_lo || lat > win_hi)
            return;
        slot = kept;
        while (slot > 0 && amp > top_amp[slot - 1])
            slot--;
        if (slot >= TOP_COUNT)
            return;
        j = (kept < TOP_COUNT) ? kept : TOP_COUNT - 1;
        while (j > slot)
        begin
            top_amp[j] = top_amp[j - 1];
            top_lat[j] = top_lat[j - 1];
            j--;
        end
        top_amp[slot] = amp;
        top_lat[slot] = lat;
        if (kept < TOP_COUNT)
            kept++;
    endfunction

    function automatic void pick_peaks(in_item_t it);
        logic signed [SAMPLE_BITS-1:0] level;
        out_item_t                     report;
        int                            k;
        level = it.sample;
        if (!run_open)
        begin
            run_level   = level;
            run_lat     = it.latency;
            run_climbed = 1'b0;
            run_open    = 1'b1;
        end
        else if (level != run_level)
        begin
            // a run that climbed and now falls is a peak, dated by its first sample
            if (run_climbed && level < run_level)
                rank_peak(run_level, run_lat);
            run_climbed = level > run_level;
            run_level   = level;
            run_lat     = it.latency;
        end
        if (!it.end_of_record)
            return;
        if (kept == 0)
        begin
            report                = '0;
            report.last           = 1'b1;
            report.total_reported = reported_total;
            peak_reports_q.push_back(report);
        end
        for (k = 0; k < kept; k++)
        begin
            if (reported_total != '1)
                reported_total = reported_total + 1'b1;
            report                = '0;
            report.peak_amplitude = top_amp[k];
            report.peak_latency   = top_lat[k];
            report.rank           = RANK_BITS'(k);
            report.found          = 1'b1;
            report.last           = (k == kept - 1);
            report.total_reported = reported_total;
            peak_reports_q.push_back(report);
        end
        run_open = 1'b0;
        kept     = 0;
    endfunction

    function automatic string describe_report(out_item_t r);
        return $sformatf("amp %0d lat %0d rank %0d found %0b last %0b total %0d",
                         $signed(r.peak_amplitude), r.peak_latency, r.rank, r.found,
                         r.last, r.total_reported);
    endfunction

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_report(out_item_t got);
        out_item_t want;
        if (peak_reports_q.size() == 0)
        begin
            note_failure({"unexpected result: ", describe_report(got)});
            return;
        end
        want = peak_reports_q.pop_front();
        if (got.peak_amplitude !== want.peak_amplitude || got.peak_latency !== want.peak_latency
            || got.rank !== want.rank || got.found !== want.found || got.last !== want.last
            || got.total_reported !== want.total_reported)
            note_failure({"expected ", describe_report(want), " got ", describe_report(got)});
    endfunction

    // driver: presents queued samples, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_item  <= '0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_backlog.size() != 0
                && !(sample_backlog[0].drain_first && (sample_valid || reports_owed != 0))
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample_item  <= sample_backlog[0].item;
                sample_valid <= 1'b1;
                void'(sample_backlog.pop_front());
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted samples, checks accepted results, drives stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            reports_owed <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                pick_peaks(sample_item);
            if (result_valid && !result_stall)
                check_report(result_item);
            reports_owed <= peak_reports_q.size();
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_sample(logic [SAMPLE_BITS-1:0] value, logic [LAT_BITS-1:0] lat,
                               logic eor, logic hold);
        queued_sample_t entry;
        entry.item.sample        = value;
        entry.item.latency       = lat;
        entry.item.end_of_record = eor;
        entry.drain_first        = hold;
        sample_backlog.push_back(entry);
    endtask

    // one record: a random walk with flats and jumps, latencies mostly near a window edge
    task automatic queue_record(int len, logic hold);
        logic signed [SAMPLE_BITS-1:0] level;
        logic [LAT_BITS-1:0]           lat;
        int                            pick;
        int                            delta;
        int                            next_level;
        int                            i;
        level = 16'($urandom);
        pick  = $urandom_range(0, 9);
        if (pick < 4)
            lat = win_lo - 16'd16 + 16'($urandom_range(0, 48));
        else if (pick < 8)
            lat = win_hi - 16'd48 + 16'($urandom_range(0, 48));
        else
            lat = 16'($urandom);
        for (i = 0; i < len; i++)
        begin
            push_sample(level, lat, i == len - 1, hold && i == 0);
            lat  = lat + 16'($urandom_range(1, 12));
            pick = $urandom_range(0, 9);
            if (pick >= 2 && pick < 9)
            begin
                delta = $urandom_range(1, 3000);
                if ($urandom_range(0, 1))
                    delta = -delta;
                next_level = int'(level) + delta;
                if (next_level > 32767)
                    next_level = 32767;
                if (next_level < -32768)
                    next_level = -32768;
                level = 16'(next_level);
            end
            else if (pick == 9)
            begin
                level = 16'($urandom);
            end
        end
    endtask

    task automatic fill_random(int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            queue_record(len, $urandom_range(0, 9) == 0);
            added += len;
        end
    endtask

    task automatic write_reg(wpp_reg_e idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_START)
            win_lo = value;
        else
            win_hi = value;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_valid || peak_reports_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 22;
        stall_pct     = 73;
        // single-sample record: nothing found
        push_sample(16'sd100, 16'd400, 1'b1, 1'b0);
        // full-scale flat peak; the run open at record end is ignored
        push_sample(16'sh8000, 16'd300, 1'b0, 1'b0);
        push_sample(16'sh7FFF, 16'd320, 1'b0, 1'b0);
        push_sample(16'sh7FFF, 16'd330, 1'b0, 1'b0);
        push_sample(16'sh8000, 16'd340, 1'b0, 1'b0);
        push_sample(16'sd5, 16'd350, 1'b0, 1'b0);
        push_sample(16'sd5, 16'd360, 1'b1, 1'b0);
        // falling first sample, four peaks with ties, last one closed by the final sample
        push_sample(16'sd30, 16'd400, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd401, 1'b0, 1'b0);
        push_sample(16'sd10, 16'd402, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd403, 1'b0, 1'b0);
        push_sample(16'sd20, 16'd404, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd405, 1'b0, 1'b0);
        push_sample(16'sd10, 16'd406, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd407, 1'b0, 1'b0);
        push_sample(16'sd10, 16'd408, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd409, 1'b1, 1'b0);
        // peaks just outside and exactly on both window limits
        push_sample(16'sd0, 16'd0, 1'b0, 1'b0);
        push_sample(16'sd7, 16'd311, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd0, 1'b0, 1'b0);
        push_sample(16'sd8, 16'd312, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd0, 1'b0, 1'b0);
        push_sample(16'sd9, 16'd512, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd0, 1'b0, 1'b0);
        push_sample(16'sd6, 16'd513, 1'b0, 1'b0);
        push_sample(16'sd0, 16'd0, 1'b1, 1'b0);
        wait_idle();

        write_reg(REG_WINDOW_START, 16'($urandom_range(0, 2000)));
        write_reg(REG_WINDOW_END, win_lo + 16'($urandom_range(50, 400)));
        fill_random(20);
        wait_idle();

        send_idle_pct = 73;
        stall_pct     = 22;
        // empty window: start above end
        write_reg(REG_WINDOW_START, 16'hFFFF);
        write_reg(REG_WINDOW_END, 16'h0000);
        fill_random(8);
        wait_idle();
        write_reg(REG_WINDOW_START, 16'h0000);
        write_reg(REG_WINDOW_END, 16'hFFFF);
        fill_random(6);
        queue_record(6, 1'b1);
        fill_random(5);
        wait_idle();

        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(REG_WINDOW_START, 16'($urandom_range(100, 60000)));
        write_reg(REG_WINDOW_END, win_lo + 16'd300);
        fill_random(12);
        queue_record(8, 1'b0);
        queue_record(1, 1'b0);
        wait_idle();
        repeat (8) @(negedge clk);

        if (error_count == 0 && peak_reports_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
